// ===== rtl/jss_pkg.sv =====
// Package for the joystick setpoint shaper: request/response payload types,
// register indexes, button bit positions and fixed-point constants.
// No dependencies.
`timescale 1ns / 1ps

package jss_pkg;

   // One joystick report.
   typedef struct packed {
      logic signed [15:0] axis_forward;
      logic signed [15:0] axis_side;
      logic        [9:0]  button_bits;
      logic signed [15:0] measured_pitch;
      logic signed [15:0] measured_yaw;
      logic signed [15:0] measured_depth;
   } jss_req_type;

   // Setpoints emitted for one report.
   typedef struct packed {
      logic               setpoint_valid;
      logic signed [15:0] surge_set;
      logic signed [15:0] sway_set;
      logic signed [15:0] yaw_set;
      logic signed [15:0] pitch_set;
      logic signed [15:0] depth_set;
      logic               disable_request;
      logic               enable_request;
   } jss_rsp_type;

   // Register map.
   typedef enum logic [2:0] {
      CSR_SURGE_GAIN  = 3'd0,
      CSR_SWAY_GAIN   = 3'd1,
      CSR_YAW_STEP    = 3'd2,
      CSR_PITCH_STEP  = 3'd3,
      CSR_DEPTH_STEP  = 3'd4,
      CSR_PITCH_LIMIT = 3'd5,
      CSR_SURGE_LIMIT = 3'd6,
      CSR_DEPTH_LIMIT = 3'd7
   } csr_index_type;

   localparam int CSR_DATA_W = 16;

   // Register reset values.
   localparam logic [15:0] SURGE_GAIN_RST  = 16'd4096;
   localparam logic [15:0] SWAY_GAIN_RST   = 16'd4096;
   localparam logic [14:0] YAW_STEP_RST    = 15'd71;
   localparam logic [14:0] PITCH_STEP_RST  = 15'd71;
   localparam logic [14:0] DEPTH_STEP_RST  = 15'd256;
   localparam logic [14:0] PITCH_LIMIT_RST = 15'd6434;
   localparam logic [14:0] SURGE_LIMIT_RST = 15'd4096;
   localparam logic [14:0] DEPTH_LIMIT_RST = 15'd1280;

   // Button bit positions.
   localparam int BTN_YAW_DOWN   = 0;
   localparam int BTN_PITCH_UP   = 1;
   localparam int BTN_YAW_UP     = 2;
   localparam int BTN_PITCH_DOWN = 3;
   localparam int BTN_SAFETY     = 4;
   localparam int BTN_DEPTH_DOWN = 5;
   localparam int BTN_CAPTURE    = 6;
   localparam int BTN_DEPTH_UP   = 7;
   localparam int BTN_DISABLE    = 8;
   localparam int BTN_ENABLE     = 9;

   // Angle constants, LSB 2^-12 rad.
   localparam logic [16:0] PI_FX        = 17'd12868;
   localparam logic [16:0] TWO_PI_FX    = 17'd25736;
   localparam logic [16:0] TWO_PI_FX_X2 = 17'(2 * 25736);
   localparam logic [16:0] TWO_PI_FX_X3 = 17'(3 * 25736);
   localparam logic [14:0] YAW_LIMIT    = 15'd12868;

endpackage

// ===== rtl/joystick_setpoint_shaper.sv =====
// Joystick setpoint shaper top level: one-report-per-cycle setpoint update while responses are taken.
// Depends on jss_pkg.
`timescale 1ns / 1ps

// Channel  Direction  Payload        Handshake
// req_     in         jss_req_type   req_valid / req_ready
// rsp_     out        jss_rsp_type   rsp_valid / rsp_ready
// csr_     in         16-bit data    csr_write, csr_index (no wait, no read-back)
//
// One request per cycle sustained while rsp_ready stays high. A request is
// held in the input register, where the setpoint update (two 16x17 multiplies,
// yaw wrap, clamps) runs against the held state; both update on the same edge
// that loads the response register, which then presents the response. Reset
// (synchronous, active high) clears holds, enable flag, valids and restores
// register defaults. A stalled response holds the input register; req_ready
// drops only when both stages are full and rsp_ready is low.

module joystick_setpoint_shaper
   import jss_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  req_valid,
   output logic                  req_ready,
   input  jss_req_type           req_data,

   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output jss_rsp_type           rsp_data,

   input  logic                  csr_write,
   input  logic [2:0]            csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   // ------------------------------------------------------------------
   // Helpers
   // ------------------------------------------------------------------

   // Hold plus or minus one step; both or neither button leaves it alone.
   function automatic logic signed [17:0] step_adjust(
      input logic signed [15:0] hold,
      input logic        [14:0] step,
      input logic               up,
      input logic               down
   );
      logic signed [17:0] h;
      logic signed [17:0] s;
      h = {{2{hold[15]}}, hold};
      s = {3'b000, step};
      if (up && !down) begin
         step_adjust = h + s;
      end else if (down && !up) begin
         step_adjust = h - s;
      end else begin
         step_adjust = h;
      end
   endfunction

   // Symmetric clamp to +/- lim.
   function automatic logic signed [15:0] clamp_sym(
      input logic signed [18:0] v,
      input logic        [14:0] lim
   );
      logic signed [18:0] pos;
      logic signed [18:0] neg;
      pos = {4'b0000, lim};
      neg = -pos;
      if (v > pos) begin
         clamp_sym = pos[15:0];
      end else if (v < neg) begin
         clamp_sym = neg[15:0];
      end else begin
         clamp_sym = v[15:0];
      end
   endfunction

   // ------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------
   logic [15:0] surge_gain_ff;
   logic [15:0] sway_gain_ff;
   logic [14:0] yaw_step_ff;
   logic [14:0] pitch_step_ff;
   logic [14:0] depth_step_ff;
   logic [14:0] pitch_limit_ff;
   logic [14:0] surge_limit_ff;
   logic [14:0] depth_limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         surge_gain_ff  <= SURGE_GAIN_RST;
         sway_gain_ff   <= SWAY_GAIN_RST;
         yaw_step_ff    <= YAW_STEP_RST;
         pitch_step_ff  <= PITCH_STEP_RST;
         depth_step_ff  <= DEPTH_STEP_RST;
         pitch_limit_ff <= PITCH_LIMIT_RST;
         surge_limit_ff <= SURGE_LIMIT_RST;
         depth_limit_ff <= DEPTH_LIMIT_RST;
      end else if (csr_write) begin
         case (csr_index_type'(csr_index))
            CSR_SURGE_GAIN:  surge_gain_ff  <= csr_wdata;
            CSR_SWAY_GAIN:   sway_gain_ff   <= csr_wdata;
            CSR_YAW_STEP:    yaw_step_ff    <= csr_wdata[14:0];
            CSR_PITCH_STEP:  pitch_step_ff  <= csr_wdata[14:0];
            CSR_DEPTH_STEP:  depth_step_ff  <= csr_wdata[14:0];
            CSR_PITCH_LIMIT: pitch_limit_ff <= csr_wdata[14:0];
            CSR_SURGE_LIMIT: surge_limit_ff <= csr_wdata[14:0];
            CSR_DEPTH_LIMIT: depth_limit_ff <= csr_wdata[14:0];
            default: ;
         endcase
      end
   end

   // ------------------------------------------------------------------
   // Handshake: input register -> update -> response register
   // ------------------------------------------------------------------
   jss_req_type req_ff;
   logic        req_valid_ff;
   jss_rsp_type rsp_ff;
   jss_rsp_type rsp_in;
   logic        rsp_valid_ff;
   logic        advance;

   // Item in the input register moves on when the response slot frees up.
   assign advance   = req_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !req_valid_ff || advance;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // ------------------------------------------------------------------
   // Held state
   // ------------------------------------------------------------------
   logic               enabled_ff,     enabled_in;
   logic signed [15:0] surge_hold_ff,  surge_hold_in;
   logic signed [15:0] sway_hold_ff,   sway_hold_in;
   logic signed [15:0] yaw_hold_ff,    yaw_hold_in;
   logic signed [15:0] pitch_hold_ff,  pitch_hold_in;
   logic signed [15:0] depth_hold_ff,  depth_hold_in;

   // ------------------------------------------------------------------
   // Setpoint update
   // ------------------------------------------------------------------
   logic [9:0]         btn;
   logic               update;
   logic signed [32:0] surge_prod;
   logic signed [32:0] sway_prod;
   logic signed [18:0] surge_scaled;   // floor(prod / 2^14)
   logic signed [18:0] sway_scaled;
   logic signed [15:0] sway_sat;
   logic signed [17:0] yaw_raw;
   logic signed [17:0] pitch_raw;
   logic signed [17:0] depth_raw;
   logic               yaw_neg;
   logic signed [17:0] yaw_neg_val;
   logic [16:0]        yaw_abs;
   logic [16:0]        yaw_ofs;
   logic [16:0]        yaw_rem;
   logic signed [17:0] yaw_mag;
   logic signed [17:0] yaw_wrap;

   assign btn    = req_ff.button_bits;
   assign update = btn[BTN_SAFETY] && enabled_ff;

   // Gains are unsigned: zero-extend before the signed multiply.
   assign surge_prod   = req_ff.axis_forward * $signed({1'b0, surge_gain_ff});
   assign sway_prod    = req_ff.axis_side * $signed({1'b0, sway_gain_ff});
   assign surge_scaled = surge_prod[32:14];
   assign sway_scaled  = sway_prod[32:14];

   always_comb begin
      if (sway_scaled > 19'sd32767) begin
         sway_sat = 16'sh7FFF;
      end else if (sway_scaled < -19'sd32768) begin
         sway_sat = 16'sh8000;
      end else begin
         sway_sat = sway_scaled[15:0];
      end
   end

   assign yaw_raw   = step_adjust(yaw_hold_ff, yaw_step_ff,
                                  btn[BTN_YAW_UP], btn[BTN_YAW_DOWN]);
   assign pitch_raw = step_adjust(pitch_hold_ff, pitch_step_ff,
                                  btn[BTN_PITCH_UP], btn[BTN_PITCH_DOWN]);
   assign depth_raw = step_adjust(depth_hold_ff, depth_step_ff,
                                  btn[BTN_DEPTH_UP], btn[BTN_DEPTH_DOWN]);

   // Yaw wrap into +/- pi on the magnitude: the truncating remainder keeps
   // the sign of the dividend, so the wrapped value is
   // sign(y) * (((|y| + pi) mod 2pi) - pi). |y| + pi stays below 4*2pi,
   // so one subtract of 2pi, 2*2pi or 3*2pi is enough.
   assign yaw_neg     = yaw_raw[17];
   assign yaw_neg_val = -yaw_raw;
   assign yaw_abs     = yaw_neg ? yaw_neg_val[16:0] : yaw_raw[16:0];
   assign yaw_ofs     = yaw_abs + PI_FX;

   always_comb begin
      if (yaw_ofs >= TWO_PI_FX_X3) begin
         yaw_rem = yaw_ofs - TWO_PI_FX_X3;
      end else if (yaw_ofs >= TWO_PI_FX_X2) begin
         yaw_rem = yaw_ofs - TWO_PI_FX_X2;
      end else if (yaw_ofs >= TWO_PI_FX) begin
         yaw_rem = yaw_ofs - TWO_PI_FX;
      end else begin
         yaw_rem = yaw_ofs;
      end
   end

   assign yaw_mag  = $signed({1'b0, yaw_rem}) - $signed({1'b0, PI_FX});
   assign yaw_wrap = yaw_neg ? -yaw_mag : yaw_mag;

   // Next state: joystick update, then disable, then capture.
   always_comb begin
      enabled_in    = enabled_ff;
      surge_hold_in = surge_hold_ff;
      sway_hold_in  = sway_hold_ff;
      yaw_hold_in   = yaw_hold_ff;
      pitch_hold_in = pitch_hold_ff;
      depth_hold_in = depth_hold_ff;

      if (update) begin
         sway_hold_in  = sway_sat;
         surge_hold_in = clamp_sym(surge_scaled, surge_limit_ff);
         yaw_hold_in   = clamp_sym({yaw_wrap[17], yaw_wrap}, YAW_LIMIT);
         pitch_hold_in = clamp_sym({pitch_raw[17], pitch_raw}, pitch_limit_ff);
         depth_hold_in = clamp_sym({depth_raw[17], depth_raw}, depth_limit_ff);
      end

      if (btn[BTN_DISABLE]) begin
         enabled_in = 1'b0;
      end

      // Capture takes the measured pose as is, no wrap or clamp.
      if (btn[BTN_CAPTURE]) begin
         pitch_hold_in = req_ff.measured_pitch;
         yaw_hold_in   = req_ff.measured_yaw;
         depth_hold_in = req_ff.measured_depth;
         surge_hold_in = 16'sd0;
         enabled_in    = 1'b1;
      end
   end

   always_comb begin
      rsp_in.setpoint_valid  = enabled_in;
      rsp_in.surge_set       = surge_hold_in;
      rsp_in.sway_set        = sway_hold_in;
      rsp_in.yaw_set         = yaw_hold_in;
      rsp_in.pitch_set       = pitch_hold_in;
      rsp_in.depth_set       = depth_hold_in;
      rsp_in.disable_request = btn[BTN_DISABLE];
      rsp_in.enable_request  = btn[BTN_ENABLE];
   end

   // ------------------------------------------------------------------
   // Registers
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         enabled_ff    <= 1'b0;
         surge_hold_ff <= '0;
         sway_hold_ff  <= '0;
         yaw_hold_ff   <= '0;
         pitch_hold_ff <= '0;
         depth_hold_ff <= '0;
      end else begin
         if (req_ready) begin
            req_valid_ff <= req_valid;
         end
         if (advance) begin
            rsp_valid_ff  <= 1'b1;
            enabled_ff    <= enabled_in;
            surge_hold_ff <= surge_hold_in;
            sway_hold_ff  <= sway_hold_in;
            yaw_hold_ff   <= yaw_hold_in;
            pitch_hold_ff <= pitch_hold_in;
            depth_hold_ff <= depth_hold_in;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers, no reset.
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         req_ff <= req_data;
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

// ===== tb/jss_setpoint_checker.sv =====
// Setpoint checker for the joystick setpoint shaper: follows register writes,
// predicts the response to every accepted request and compares it field by field.
// Depends on jss_pkg.
`timescale 1ns / 1ps

module jss_setpoint_checker
   import jss_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  jss_req_type           req_data,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  jss_rsp_type           rsp_data,
   input  logic                  csr_write,
   input  logic [2:0]            csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int                    pending,
   output int                    mismatches
);

   localparam int HALF_TURN = 12868;   // pi, LSB 2^-12
   localparam int FULL_TURN = 25736;
   localparam int YAW_CLAMP = 12868;

   int surge_gain, sway_gain, yaw_step, pitch_step, depth_step;
   int pitch_limit, surge_limit, depth_limit;

   logic enabled;
   int   surge_hold, sway_hold, yaw_hold, pitch_hold, depth_hold;

   jss_rsp_type expected_setpoints[$];

   initial begin
      pending    = 0;
      mismatches = 0;
   end

   function automatic int clamp_symmetric(longint v, longint lim);
      if (v > lim) return int'(lim);
      if (v < -lim) return int'(-lim);
      return int'(v);
   endfunction

   // Advances the held state by one request, returns the setpoints it emits.
   function automatic jss_rsp_type shape_setpoints(jss_req_type r);
      logic [9:0]  b;
      longint      surge, sway;
      int          y, s, p, d;
      jss_rsp_type e;
      b = r.button_bits;
      if (b[BTN_SAFETY] && enabled) begin
         // floor of axis * gain / 2^14
         surge = (longint'($signed(r.axis_forward)) * longint'(surge_gain)) >>> 14;
         sway  = (longint'($signed(r.axis_side)) * longint'(sway_gain)) >>> 14;
         y = yaw_hold + yaw_step * (int'(b[BTN_YAW_UP]) - int'(b[BTN_YAW_DOWN]));
         p = pitch_hold + pitch_step * (int'(b[BTN_PITCH_UP]) - int'(b[BTN_PITCH_DOWN]));
         d = depth_hold + depth_step * (int'(b[BTN_DEPTH_UP]) - int'(b[BTN_DEPTH_DOWN]));
         s = (y >= 0) ? HALF_TURN : -HALF_TURN;
         y = ((y + s) % FULL_TURN) - s;   // truncating remainder
         if (sway > 32767) sway = 32767;
         if (sway < -32768) sway = -32768;
         sway_hold  = int'(sway);
         surge_hold = clamp_symmetric(surge, surge_limit);
         yaw_hold   = clamp_symmetric(y, YAW_CLAMP);
         pitch_hold = clamp_symmetric(p, pitch_limit);
         depth_hold = clamp_symmetric(d, depth_limit);
      end
      if (b[BTN_DISABLE]) enabled = 1'b0;
      // capture comes after disable, so it wins
      if (b[BTN_CAPTURE]) begin
         pitch_hold = $signed(r.measured_pitch);
         yaw_hold   = $signed(r.measured_yaw);
         depth_hold = $signed(r.measured_depth);
         surge_hold = 0;
         enabled    = 1'b1;
      end
      e.setpoint_valid  = enabled;
      e.surge_set       = 16'(surge_hold);
      e.sway_set        = 16'(sway_hold);
      e.yaw_set         = 16'(yaw_hold);
      e.pitch_set       = 16'(pitch_hold);
      e.depth_set       = 16'(depth_hold);
      e.disable_request = b[BTN_DISABLE];
      e.enable_request  = b[BTN_ENABLE];
      return e;
   endfunction

   always @(posedge clock) begin
      jss_rsp_type want;
      logic        differs;
      if (reset) begin
         surge_gain  = int'(SURGE_GAIN_RST);
         sway_gain   = int'(SWAY_GAIN_RST);
         yaw_step    = int'(YAW_STEP_RST);
         pitch_step  = int'(PITCH_STEP_RST);
         depth_step  = int'(DEPTH_STEP_RST);
         pitch_limit = int'(PITCH_LIMIT_RST);
         surge_limit = int'(SURGE_LIMIT_RST);
         depth_limit = int'(DEPTH_LIMIT_RST);
         enabled     = 1'b0;
         surge_hold  = 0;
         sway_hold   = 0;
         yaw_hold    = 0;
         pitch_hold  = 0;
         depth_hold  = 0;
         expected_setpoints.delete();
      end else begin
         if (csr_write) begin
            case (csr_index_type'(csr_index))
               CSR_SURGE_GAIN:  surge_gain  = int'(csr_wdata);
               CSR_SWAY_GAIN:   sway_gain   = int'(csr_wdata);
               CSR_YAW_STEP:    yaw_step    = int'(csr_wdata[14:0]);
               CSR_PITCH_STEP:  pitch_step  = int'(csr_wdata[14:0]);
               CSR_DEPTH_STEP:  depth_step  = int'(csr_wdata[14:0]);
               CSR_PITCH_LIMIT: pitch_limit = int'(csr_wdata[14:0]);
               CSR_SURGE_LIMIT: surge_limit = int'(csr_wdata[14:0]);
               CSR_DEPTH_LIMIT: depth_limit = int'(csr_wdata[14:0]);
               default: ;
            endcase
         end
         if (req_valid && req_ready)
            expected_setpoints.push_back(shape_setpoints(req_data));
         if (rsp_valid && rsp_ready) begin
            if (expected_setpoints.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("setpoint error %0d: response with none expected", mismatches);
            end else begin
               want = expected_setpoints.pop_front();
               differs = (want.setpoint_valid  != rsp_data.setpoint_valid)  ||
                         (want.surge_set       != rsp_data.surge_set)       ||
                         (want.sway_set        != rsp_data.sway_set)        ||
                         (want.yaw_set         != rsp_data.yaw_set)         ||
                         (want.pitch_set       != rsp_data.pitch_set)       ||
                         (want.depth_set       != rsp_data.depth_set)       ||
                         (want.disable_request != rsp_data.disable_request) ||
                         (want.enable_request  != rsp_data.enable_request);
               if (differs) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("setpoint error %0d: want v=%0b su=%0d sw=%0d y=%0d p=%0d d=%0d dis=%0b en=%0b",
                              mismatches, want.setpoint_valid, want.surge_set, want.sway_set,
                              want.yaw_set, want.pitch_set, want.depth_set,
                              want.disable_request, want.enable_request);
                     $display("                   got  v=%0b su=%0d sw=%0d y=%0d p=%0d d=%0d dis=%0b en=%0b",
                              rsp_data.setpoint_valid, rsp_data.surge_set, rsp_data.sway_set,
                              rsp_data.yaw_set, rsp_data.pitch_set, rsp_data.depth_set,
                              rsp_data.disable_request, rsp_data.enable_request);
                  end
               end
            end
         end
      end
      pending <= expected_setpoints.size();
   end

endmodule

// ===== tb/joystick_setpoint_shaper_test.sv =====
// Top of the joystick setpoint shaper testbench: clock, reset, request stimulus,
// register settings, response back-pressure and the final verdict.
// Depends on jss_pkg, joystick_setpoint_shaper and jss_setpoint_checker.
`timescale 1ns / 1ps

module joystick_setpoint_shaper_test;
   import jss_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int PHASE_COUNT = 6;
   localparam int PHASE_ITEMS = 250;

   // register setting styles
   localparam int CFG_ZERO    = 0;
   localparam int CFG_FULL    = 1;
   localparam int CFG_MIXED   = 2;
   localparam int CFG_DEFAULT = 3;

   // one-hot button masks
   localparam logic [9:0] PRESS_YAW_DOWN   = 10'b1 << BTN_YAW_DOWN;
   localparam logic [9:0] PRESS_PITCH_UP   = 10'b1 << BTN_PITCH_UP;
   localparam logic [9:0] PRESS_YAW_UP     = 10'b1 << BTN_YAW_UP;
   localparam logic [9:0] PRESS_PITCH_DOWN = 10'b1 << BTN_PITCH_DOWN;
   localparam logic [9:0] PRESS_SAFETY     = 10'b1 << BTN_SAFETY;
   localparam logic [9:0] PRESS_DEPTH_DOWN = 10'b1 << BTN_DEPTH_DOWN;
   localparam logic [9:0] PRESS_CAPTURE    = 10'b1 << BTN_CAPTURE;
   localparam logic [9:0] PRESS_DEPTH_UP   = 10'b1 << BTN_DEPTH_UP;
   localparam logic [9:0] PRESS_DISABLE    = 10'b1 << BTN_DISABLE;
   localparam logic [9:0] PRESS_ENABLE     = 10'b1 << BTN_ENABLE;
   localparam logic [9:0] STEER_UP   = PRESS_YAW_UP | PRESS_PITCH_UP | PRESS_DEPTH_UP;
   localparam logic [9:0] STEER_DOWN = PRESS_YAW_DOWN | PRESS_PITCH_DOWN | PRESS_DEPTH_DOWN;
   localparam logic [9:0] STEER_MASK = STEER_UP | STEER_DOWN;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   jss_req_type           req_data;
   logic                  rsp_valid;
   logic                  rsp_ready;
   jss_rsp_type           rsp_data;
   logic                  csr_write;
   logic [2:0]            csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   int pending;       // responses still owed, from the checker
   int mismatches;    // failures seen by the checker
   int cycles = 0;
   bit calm   = 0;    // set for the last phase: no idling on either side

   csr_index_type reg_order [8] = '{CSR_SURGE_GAIN, CSR_SWAY_GAIN, CSR_YAW_STEP,
                                    CSR_PITCH_STEP, CSR_DEPTH_STEP, CSR_PITCH_LIMIT,
                                    CSR_SURGE_LIMIT, CSR_DEPTH_LIMIT};
   logic [15:0] reg_default [8] = '{SURGE_GAIN_RST, SWAY_GAIN_RST, 16'(YAW_STEP_RST),
                                    16'(PITCH_STEP_RST), 16'(DEPTH_STEP_RST),
                                    16'(PITCH_LIMIT_RST), 16'(SURGE_LIMIT_RST),
                                    16'(DEPTH_LIMIT_RST)};

   joystick_setpoint_shaper uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   jss_setpoint_checker setpoint_check (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data),
      .csr_write  (csr_write),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .pending    (pending),
      .mismatches (mismatches)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Watchdog: a hung handshake ends the run as a failure.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("joystick_setpoint_shaper: mismatch");
         $finish;
      end
   end

   function automatic jss_req_type report(int fwd, int side, logic [9:0] buttons,
                                          int m_pitch, int m_yaw, int m_depth);
      jss_req_type r;
      r.axis_forward   = 16'(fwd);
      r.axis_side      = 16'(side);
      r.button_bits    = buttons;
      r.measured_pitch = 16'(m_pitch);
      r.measured_yaw   = 16'(m_yaw);
      r.measured_depth = 16'(m_depth);
      return r;
   endfunction

   // Stick axis in Q1.14, full deflection and center now and then.
   function automatic int random_axis();
      case ($urandom_range(0, 9))
         0:       return -16384;
         1:       return 16384;
         2:       return 0;
         default: return int'($urandom_range(0, 32768)) - 16384;
      endcase
   endfunction

   // Measured pose: half full 16-bit range, half near the angle limits.
   function automatic int random_measure();
      if ($urandom_range(0, 1) == 0) return int'(16'($urandom));
      return int'($urandom_range(0, 26000)) - 13000;
   endfunction

   // Mostly safety held with random steering; capture and disable now and
   // then so the flag toggles; a tenth of requests are raw button noise.
   function automatic jss_req_type random_report();
      logic [9:0] b;
      if ($urandom_range(0, 9) == 0) begin
         b = 10'($urandom);
      end else begin
         b = 10'($urandom) & STEER_MASK;
         if ($urandom_range(0, 9) != 0) b |= PRESS_SAFETY;
         if ($urandom_range(0, 15) == 0) b |= PRESS_CAPTURE;
         if ($urandom_range(0, 24) == 0) b |= PRESS_DISABLE;
         if ($urandom_range(0, 4) == 0) b |= PRESS_ENABLE;
      end
      return report(random_axis(), random_axis(), b,
                    random_measure(), random_measure(), random_measure());
   endfunction

   // Called at a rising edge; returns at the edge where the request is taken.
   // req_ready is sampled at the falling edge, where it is settled.
   task automatic send_report(input jss_req_type r);
      req_valid <= 1'b1;
      req_data  <= r;
      do @(negedge clock); while (!req_ready);
      @(posedge clock);
   endtask

   task automatic pause_sender(input int n);
      req_valid <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   // Sender holds off until every response is back, then the pipe settles.
   task automatic drain();
      req_valid <= 1'b0;
      do @(negedge clock); while (pending != 0);
      repeat (4) @(posedge clock);
   endtask

   // Writes all eight registers back to back. 15-bit registers get 16-bit
   // values so the top bit is dropped by the block.
   task automatic load_registers(input int style);
      logic [15:0] v;
      for (int i = 0; i < 8; i++) begin
         case (style)
            CFG_ZERO:    v = 16'h0000;
            CFG_FULL:    v = 16'hFFFF;
            CFG_DEFAULT: v = reg_default[i];
            default: begin
               case ($urandom_range(0, 4))
                  0:       v = 16'h0000;
                  1:       v = 16'hFFFF;
                  2:       v = 16'($urandom);
                  3:       v = 16'($urandom_range(0, 512));
                  default: v = reg_default[i];
               endcase
            end
         endcase
         csr_write <= 1'b1;
         csr_index <= reg_order[i];
         csr_wdata <= v;
         @(posedge clock);
      end
      csr_write <= 1'b0;
   endtask

   // Response back-pressure: random stall bursts, none once calm is set.
   initial begin
      rsp_ready = 1'b0;
      @(posedge clock);
      forever begin
         if (!calm && $urandom_range(0, 3) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         repeat ($urandom_range(1, 20)) @(posedge clock);
      end
   end

   initial begin
      int style;
      clock     = 1'b0;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      csr_write = 1'b0;
      csr_index = CSR_SURGE_GAIN;
      csr_wdata = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // --- directed, reset register values ---
      // safety held but not yet enabled: holds stay zero
      send_report(report(16384, -16384, PRESS_SAFETY, 0, 0, 0));
      // capture loads extreme measured pose unclamped
      send_report(report(0, 0, PRESS_CAPTURE, 32767, -32768, -32768));
      // full deflection: surge reaches its limit, pitch and depth clamp, yaw wraps from far outside +-pi
      send_report(report(16384, -16384, PRESS_SAFETY | PRESS_YAW_UP, 0, 0, 0));
      // -1 times gain rounds toward minus infinity
      send_report(report(-1, 1, PRESS_SAFETY | PRESS_YAW_DOWN | PRESS_PITCH_UP |
                         PRESS_DEPTH_UP, 0, 0, 0));
      send_report(report(0, 0, PRESS_SAFETY | PRESS_PITCH_DOWN | PRESS_DEPTH_DOWN |
                         PRESS_YAW_UP | PRESS_YAW_DOWN, 0, 0, 0));
      // up and down together cancel
      send_report(report(8191, -8193, PRESS_SAFETY | STEER_MASK, 0, 0, 0));
      send_report(report(100, 100, PRESS_SAFETY | PRESS_ENABLE, 0, 0, 0));
      // update runs, then disable clears the flag
      send_report(report(-16384, 16384, PRESS_SAFETY | PRESS_DISABLE, 0, 0, 0));
      // disabled: safety has no effect
      send_report(report(16384, 16384, PRESS_SAFETY | STEER_UP, 0, 0, 0));
      // disable and capture together: capture wins
      send_report(report(0, 0, PRESS_DISABLE | PRESS_CAPTURE, 12868, 12868, 1280));
      // yaw steps past +pi and wraps to the negative side
      send_report(report(0, 0, PRESS_SAFETY | PRESS_YAW_UP, 0, 0, 0));
      send_report(report(0, 0, PRESS_CAPTURE, -6434, -12868, -1280));
      // yaw steps past -pi and wraps to the positive side
      send_report(report(0, 0, PRESS_SAFETY | PRESS_YAW_DOWN | PRESS_PITCH_DOWN |
                         PRESS_DEPTH_DOWN, 0, 0, 0));
      send_report(report(16384, -16384, 10'h3FF, -1, -1, -1));
      send_report(report(0, 0, 10'h000, 0, 0, 0));

      // --- directed, every register at its top value ---
      drain();
      load_registers(CFG_FULL);
      send_report(report(0, 0, PRESS_CAPTURE, -32768, 32767, 32767));
      // sway saturates high, surge clamps at the limit
      send_report(report(16384, 16384, PRESS_SAFETY | STEER_UP, 0, 0, 0));
      // sway saturates low
      send_report(report(-16384, -16384, PRESS_SAFETY | STEER_DOWN, 0, 0, 0));
      send_report(report(-16384, 16384, PRESS_SAFETY | STEER_DOWN, 0, 0, 0));

      // --- directed, every register zero: surge, sway, pitch and depth pinned to zero ---
      drain();
      load_registers(CFG_ZERO);
      send_report(report(0, 0, PRESS_CAPTURE, 300, -300, 300));
      send_report(report(16384, -16384, PRESS_SAFETY | STEER_UP, 0, 0, 0));
      send_report(report(-16384, 16384, PRESS_SAFETY | STEER_DOWN, 0, 0, 0));

      // --- random phases, each under its own register setting ---
      for (int ph = 0; ph < PHASE_COUNT; ph++) begin
         drain();
         style = (ph == 1) ? CFG_FULL :
                 (ph == 3) ? CFG_ZERO :
                 (ph == PHASE_COUNT - 1) ? CFG_DEFAULT : CFG_MIXED;
         load_registers(style);
         if (ph == PHASE_COUNT - 1) calm = 1;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (!calm && $urandom_range(0, 4) == 0)
               pause_sender($urandom_range(1, 14));
            send_report(random_report());
         end
      end

      drain();
      repeat (6) @(posedge clock);
      if (mismatches == 0 && pending == 0)
         $display("joystick_setpoint_shaper: match");
      else
         $display("joystick_setpoint_shaper: mismatch");
      $finish;
   end

endmodule
